// File: rtl/core/threshold_crossing_latency_meter_core_assert.svh
// Assertion macros used by the latency meter datapath.
`ifndef THRESHOLD_CROSSING_LATENCY_METER_CORE_ASSERT_SVH
`define THRESHOLD_CROSSING_LATENCY_METER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tclm_pkg.sv
// Shared types and constants of the threshold crossing latency meter.
package tclm_pkg;

  localparam int CHANNELS    = 8;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_EXT_W    = 7;
  localparam int CMD_W       = 2;
  localparam int CHANNEL_W   = 3;
  localparam int VALUE_W     = 32;
  localparam int THRESHOLD_W = 31;
  localparam int STAMP_W     = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2
  } tclm_cmd_code_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } tclm_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } tclm_ctrl_t;

endpackage

// File: rtl/core/threshold_crossing_latency_meter_core.sv
// Top level of the threshold crossing latency meter core.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | start / busy       | in_command, in_channel, in_value,
//            |                    | in_threshold, in_timestamp
//   result   | out_valid (strobe) | out_result_channel, out_started,
//            |                    | out_completed, out_latency_valid, out_latency
//
// A transaction is taken when start is high and busy is low; busy is high for
// the one execute cycle that follows, so none is taken in that cycle.
// The item registers capture a transaction at acceptance; the execute cycle
// does the read-modify-write of the channel state and loads the result strobe.
// rst_n is synchronous; it clears held and above-now flags, sets above-before.
// The receiver cannot stall; each result is shown for one cycle only.
module threshold_crossing_latency_meter_core
  import tclm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          in_command,
  input  logic [CHANNEL_W-1:0]      in_channel,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [THRESHOLD_W-1:0]    in_threshold,
  input  logic [STAMP_W-1:0]        in_timestamp,
  output logic                      out_valid,
  output logic [CHANNEL_W-1:0]      out_result_channel,
  output logic                      out_started,
  output logic                      out_completed,
  output logic                      out_latency_valid,
  output logic [STAMP_W-1:0]        out_latency
);

  tclm_ctrl_t ctrl;

  tclm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  tclm_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .in_command         (in_command),
    .in_channel         (in_channel),
    .in_value           (in_value),
    .in_threshold       (in_threshold),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_result_channel (out_result_channel),
    .out_started        (out_started),
    .out_completed      (out_completed),
    .out_latency_valid  (out_latency_valid),
    .out_latency        (out_latency)
  );

endmodule

// File: rtl/core/tclm_ctrl.sv
// Controller state machine of the latency meter: accept, then execute.
module tclm_ctrl
  import tclm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output tclm_ctrl_t ctrl
);

  tclm_state_t state_r;
  tclm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctrl.capture = 1'b0;
    ctrl.exec    = 1'b0;
    busy         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        ctrl.exec = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/tclm_datapath.sv
// Datapath of the latency meter: item register, channel state and result register.
module tclm_datapath
  import tclm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  tclm_ctrl_t             ctrl,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [CHANNEL_W-1:0]   in_channel,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [THRESHOLD_W-1:0] in_threshold,
  input  logic [STAMP_W-1:0]     in_timestamp,
  output logic                   out_valid,
  output logic [CHANNEL_W-1:0]   out_result_channel,
  output logic                   out_started,
  output logic                   out_completed,
  output logic                   out_latency_valid,
  output logic [STAMP_W-1:0]     out_latency
);

  logic [CMD_W-1:0]       cmd_r;
  logic [CHANNEL_W-1:0]   ch_r;
  logic [VALUE_W-1:0]     value_r;
  logic [THRESHOLD_W-1:0] thr_r;
  logic [STAMP_W-1:0]     ts_r;

  logic [1:0]         above_now_r    [CHANNELS];
  logic [1:0]         above_before_r [CHANNELS];
  logic [CHANNELS-1:0] start_held_r;
  logic [CHANNELS-1:0] result_held_r;
  logic [STAMP_W-1:0] start_stamp_r  [CHANNELS];
  logic [STAMP_W-1:0] result_value_r [CHANNELS];

  logic               out_valid_r;
  logic [CHANNEL_W-1:0] out_ch_r;
  logic               out_started_r;
  logic               out_completed_r;
  logic               out_lat_valid_r;
  logic [STAMP_W-1:0] out_lat_r;

  logic [CH_EXT_W-1:0]    ch_ext;
  logic [CH_IDX_W-1:0]    idx;
  logic                   in_range;
  logic [VALUE_W-1:0]     neg_value;
  logic [THRESHOLD_W-1:0] mag;
  logic                   above;

  logic [1:0]         now_nxt;
  logic [1:0]         before_nxt;
  logic               sh_nxt;
  logic               rh_nxt;
  logic [STAMP_W-1:0] stamp_nxt;
  logic [STAMP_W-1:0] rv_nxt;
  logic               started;
  logic               completed;
  logic               lat_valid;
  logic [STAMP_W-1:0] lat;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r   <= in_command;
      ch_r    <= in_channel;
      value_r <= in_value;
      thr_r   <= in_threshold;
      ts_r    <= in_timestamp;
    end
  end

  assign ch_ext   = {{(CH_EXT_W-CHANNEL_W){1'b0}}, ch_r};
  assign idx      = ch_ext[CH_IDX_W-1:0];
  assign in_range = ch_ext < CH_EXT_W'(CHANNELS);

  assign neg_value = ~value_r + {{(VALUE_W-1){1'b0}}, 1'b1};

  always_comb begin
    if (!value_r[VALUE_W-1]) begin
      mag = value_r[THRESHOLD_W-1:0];
    end else if (neg_value[VALUE_W-1]) begin
      mag = {THRESHOLD_W{1'b1}};
    end else begin
      mag = neg_value[THRESHOLD_W-1:0];
    end
  end

  assign above = mag >= thr_r;

  always_comb begin
    now_nxt    = above_now_r[idx];
    before_nxt = above_before_r[idx];
    sh_nxt     = start_held_r[idx];
    rh_nxt     = result_held_r[idx];
    stamp_nxt  = start_stamp_r[idx];
    rv_nxt     = result_value_r[idx];
    started    = 1'b0;
    completed  = 1'b0;
    case (cmd_r)
      CMD_START: begin
        before_nxt[0] = now_nxt[0];
        now_nxt[0]    = above;
        if (!above) begin
          sh_nxt = 1'b0;
        end else if (!before_nxt[0] && !sh_nxt && !rh_nxt) begin
          stamp_nxt = ts_r;
          sh_nxt    = 1'b1;
          started   = 1'b1;
        end
      end
      CMD_END: begin
        before_nxt[1] = now_nxt[1];
        now_nxt[1]    = above;
        if (!above) begin
          sh_nxt = 1'b0;
        end else if (sh_nxt && !rh_nxt) begin
          rv_nxt    = ts_r - stamp_nxt;
          rh_nxt    = 1'b1;
          completed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    lat_valid = rh_nxt;
    lat       = rh_nxt ? rv_nxt : '0;
    if (cmd_r == CMD_READ && lat_valid) begin
      sh_nxt = 1'b0;
      rh_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_held_r  <= '0;
      result_held_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        above_now_r[i]    <= 2'b00;
        above_before_r[i] <= 2'b11;
      end
    end else if (ctrl.exec && in_range) begin
      above_now_r[idx]    <= now_nxt;
      above_before_r[idx] <= before_nxt;
      start_held_r[idx]   <= sh_nxt;
      result_held_r[idx]  <= rh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && in_range) begin
      start_stamp_r[idx]  <= stamp_nxt;
      result_value_r[idx] <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_ch_r        <= ch_r;
      out_started_r   <= in_range & started;
      out_completed_r <= in_range & completed;
      out_lat_valid_r <= in_range & lat_valid;
      out_lat_r       <= in_range ? lat : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_channel = out_ch_r;
  assign out_started        = out_started_r;
  assign out_completed      = out_completed_r;
  assign out_latency_valid  = out_lat_valid_r;
  assign out_latency        = out_lat_r;

`include "threshold_crossing_latency_meter_core_assert.svh"

  `TCLM_ASSERT_NEXT(a_strobe_follows_exec, ctrl.exec, out_valid, "result strobe missing after execute")
  `TCLM_ASSERT_NOW(a_no_start_and_end, out_valid, !(out_started && out_completed), "start and end in one transaction")
  `TCLM_ASSERT_NOW(a_latency_zero_when_invalid, out_valid && !out_latency_valid, out_latency == '0, "latency nonzero without valid")
  `TCLM_ASSERT_NOW(a_complete_holds_latency, out_valid && out_completed, out_latency_valid, "completion without held latency")

endmodule

// File: sim/threshold_crossing_latency_meter_core_test.sv
// Self-checking testbench for the threshold crossing latency meter core.
module threshold_crossing_latency_meter_core_test
  import tclm_pkg::*;
();

  localparam int ITEM_TOTAL = 1100;
  localparam int TAIL_ITEMS = 120;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [CHANNEL_W-1:0]   ch;
    logic [VALUE_W-1:0]     value;
    logic [THRESHOLD_W-1:0] thr;
    logic [STAMP_W-1:0]     stamp;
  } sample_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] chan;
    logic                 started;
    logic                 completed;
    logic                 held;
    logic [STAMP_W-1:0]   latency;
  } reading_t;

  typedef struct packed {
    sample_t  s;
    bit       typed;
    reading_t want;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [CMD_W-1:0]          in_command;
  logic [CHANNEL_W-1:0]      in_channel;
  logic signed [VALUE_W-1:0] in_value;
  logic [THRESHOLD_W-1:0]    in_threshold;
  logic [STAMP_W-1:0]        in_timestamp;
  logic                      out_valid;
  logic [CHANNEL_W-1:0]      out_result_channel;
  logic                      out_started;
  logic                      out_completed;
  logic                      out_latency_valid;
  logic [STAMP_W-1:0]        out_latency;

  threshold_crossing_latency_meter_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_channel         (in_channel),
    .in_value           (in_value),
    .in_threshold       (in_threshold),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_result_channel (out_result_channel),
    .out_started        (out_started),
    .out_completed      (out_completed),
    .out_latency_valid  (out_latency_valid),
    .out_latency        (out_latency)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [1:0]         flag_now    [CHANNELS];
  logic [1:0]         flag_prev   [CHANNELS];
  logic               run_open    [CHANNELS];
  logic [STAMP_W-1:0] run_stamp   [CHANNELS];
  logic               lat_held    [CHANNELS];
  logic [STAMP_W-1:0] lat_value   [CHANNELS];

  reading_t pending_readings[$];
  row_t     directed_rows[$];
  int       mismatch_count = 0;
  int       sent_count = 0;
  reading_t due;
  reading_t seen;

  function automatic reading_t meter_predict(sample_t s);
    reading_t r;
    logic [31:0] mag;
    bit above;
    int c;
    int side;
    r = '0;
    r.chan = s.ch;
    c = int'(s.ch);
    if (c >= CHANNELS) return r;
    if (s.cmd == CMD_START || s.cmd == CMD_END) begin
      side = (s.cmd == CMD_END) ? 1 : 0;
      mag = s.value[31] ? -s.value : s.value;
      if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
      above = mag >= {1'b0, s.thr};
      flag_prev[c][side] = flag_now[c][side];
      flag_now[c][side] = above;
      if (!above) run_open[c] = 1'b0;
      if (s.cmd == CMD_START) begin
        if (!flag_prev[c][0] && flag_now[c][0] && !run_open[c] && !lat_held[c]) begin
          run_stamp[c] = s.stamp;
          run_open[c] = 1'b1;
          r.started = 1'b1;
        end
      end else if (above && run_open[c] && !lat_held[c]) begin
        lat_value[c] = s.stamp - run_stamp[c];
        lat_held[c] = 1'b1;
        r.completed = 1'b1;
      end
    end
    r.held = lat_held[c];
    r.latency = lat_held[c] ? lat_value[c] : '0;
    if (s.cmd == CMD_READ && lat_held[c]) begin
      run_open[c] = 1'b0;
      lat_held[c] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_value(logic [30:0] thr, bit want_above);
    logic [31:0] mag;
    logic [31:0] span;
    if (want_above) begin
      span = 32'h7FFF_FFFF - {1'b0, thr};
      if ($urandom_range(0, 1) == 0 || span < 4) mag = {1'b0, thr} + $urandom_range(0, span);
      else mag = {1'b0, thr} + $urandom_range(0, 3);
      if (mag == 32'h7FFF_FFFF && $urandom_range(0, 1) == 1) return 32'h8000_0000;
    end else begin
      if ($urandom_range(0, 1) == 0) mag = $urandom_range(0, {1'b0, thr} - 1);
      else mag = {1'b0, thr} - 1;
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic sample_t noise_sample();
    sample_t s;
    s.cmd = CMD_W'($urandom_range(0, 3));
    s.ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
    s.value = $urandom;
    s.thr = THRESHOLD_W'($urandom);
    s.stamp = $urandom;
    return s;
  endfunction

  task automatic issue(sample_t s, bit typed, reading_t want);
    int gap;
    if (sent_count < ITEM_TOTAL - TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_command <= s.cmd;
    in_channel <= s.ch;
    in_value <= s.value;
    in_threshold <= s.thr;
    in_timestamp <= s.stamp;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (typed) begin
      void'(meter_predict(s));
      pending_readings.push_back(want);
    end else begin
      pending_readings.push_back(meter_predict(s));
    end
    sent_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      seen = {out_result_channel, out_started, out_completed, out_latency_valid, out_latency};
      if (pending_readings.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result on ch%0d at %0t", out_result_channel, $time);
        mismatch_count++;
      end else begin
        due = pending_readings.pop_front();
        if (seen.chan !== due.chan || seen.started !== due.started ||
            seen.completed !== due.completed || seen.held !== due.held ||
            seen.latency !== due.latency) begin
          if (mismatch_count < 10)
            $display("mismatch at %0t: exp ch%0d s%b c%b v%b lat %h, got ch%0d s%b c%b v%b lat %h",
                     $time, due.chan, due.started, due.completed, due.held, due.latency,
                     seen.chan, seen.started, seen.completed, seen.held, seen.latency);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    sample_t s;
    logic [STAMP_W-1:0] now_stamp;
    logic [THRESHOLD_W-1:0] thr;
    logic [CHANNEL_W-1:0] ch;
    int guard;

    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_START;
    in_channel = '0;
    in_value = '0;
    in_threshold = '0;
    in_timestamp = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      flag_now[i] = 2'b00;
      flag_prev[i] = 2'b11;
      run_open[i] = 1'b0;
      run_stamp[i] = '0;
      lat_held[i] = 1'b0;
      lat_value[i] = '0;
    end

    directed_rows.push_back('{'{CMD_READ,   3'd0, 32'd0, 31'd0, 32'd0}, 1'b1,
                              '{3'd0, 1'b0, 1'b0, 1'b0, 32'd0}});
    directed_rows.push_back('{'{CMD_UNUSED, 3'd1, 32'h7FFF_FFFF, 31'd0, 32'hFFFF_FFFF}, 1'b1,
                              '{3'd1, 1'b0, 1'b0, 1'b0, 32'd0}});
    directed_rows.push_back('{'{CMD_START,  3'd2, 32'd100, 31'd50, 32'd10}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_END,    3'd2, -32'sd200, 31'd150, 32'd5}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_START,  3'd2, 32'd100, 31'd50, 32'd20}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_READ,   3'd2, 32'd0, 31'd0, 32'd0}, 1'b1,
                              '{3'd2, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFB}});
    directed_rows.push_back('{'{CMD_READ,   3'd2, 32'd0, 31'd0, 32'd0}, 1'b1,
                              '{3'd2, 1'b0, 1'b0, 1'b0, 32'd0}});
    directed_rows.push_back('{'{CMD_START,  3'd3, 32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF},
                              1'b0, '0});
    directed_rows.push_back('{'{CMD_END,    3'd3, 32'd0, 31'd1, 32'd0}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_END,    3'd3, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd3}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_START,  3'd3, 32'h7FFF_FFFF, 31'd0, 32'd4}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_START,  3'd3, 32'hFFFF_FFFF, 31'd2, 32'd5}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_START,  3'd3, 32'hFFFF_FFFE, 31'd2, 32'd6}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_START,  3'd3, 32'd1, 31'h7FFF_FFFF, 32'd7}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_END,    3'd3, 32'd9, 31'd9, 32'd8}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_START,  3'd4, 32'd0, 31'd0, 32'd100}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_END,    3'd4, 32'h8000_0001, 31'h7FFF_FFFE, 32'd99},
                              1'b0, '0});
    directed_rows.push_back('{'{CMD_END,    3'd4, 32'd5, 31'd5, 32'd200}, 1'b0, '0});
    directed_rows.push_back('{'{CMD_UNUSED, 3'd4, 32'd0, 31'd0, 32'd0}, 1'b1,
                              '{3'd4, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF}});
    directed_rows.push_back('{'{CMD_READ,   3'd4, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'd0},
                              1'b0, '0});
    directed_rows.push_back('{'{CMD_START,  3'd7, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFF0},
                              1'b0, '0});
    directed_rows.push_back('{'{CMD_END,    3'd7, 32'h8000_0000, 31'd0, 32'h0000_000F},
                              1'b0, '0});
    directed_rows.push_back('{'{CMD_READ,   3'd7, 32'd0, 31'd0, 32'd0}, 1'b1,
                              '{3'd7, 1'b0, 1'b0, 1'b1, 32'h0000_001F}});
    directed_rows.push_back('{'{CMD_READ,   3'd5, 32'd0, 31'd0, 32'd0}, 1'b1,
                              '{3'd5, 1'b0, 1'b0, 1'b0, 32'd0}});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

    now_stamp = $urandom;
    while (sent_count < ITEM_TOTAL) begin
      if ($urandom_range(0, 3) == 0) begin
        issue(noise_sample(), 1'b0, '0);
      end else begin
        ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
        thr = $urandom_range(0, 1) ? THRESHOLD_W'($urandom_range(1, 1000))
                                   : THRESHOLD_W'($urandom_range(1, 32'h7FFF_FFFF));
        now_stamp += $urandom_range(1, 300);
        if ($urandom_range(0, 3) != 0) begin
          s = '{CMD_START, ch, pick_value(thr, 1'b0), thr, now_stamp};
          issue(s, 1'b0, '0);
        end
        now_stamp += $urandom_range(1, 300);
        s = '{CMD_START, ch, pick_value(thr, 1'b1), thr, now_stamp};
        issue(s, 1'b0, '0);
        if ($urandom_range(0, 4) == 0) begin
          s = '{CMD_END, ch, pick_value(thr, 1'b0), thr, now_stamp + 1};
          issue(s, 1'b0, '0);
        end
        if ($urandom_range(0, 3) == 0) issue(noise_sample(), 1'b0, '0);
        if ($urandom_range(0, 7) == 0) now_stamp += $urandom;
        else now_stamp += $urandom_range(0, 5000);
        thr = $urandom_range(0, 1) ? THRESHOLD_W'($urandom_range(0, 1000))
                                   : THRESHOLD_W'($urandom_range(0, 32'h7FFF_FFFF));
        s = '{CMD_END, ch, pick_value(thr, 1'b1), thr, now_stamp};
        issue(s, 1'b0, '0);
        if ($urandom_range(0, 3) != 0) begin
          s = noise_sample();
          s.cmd = CMD_READ;
          s.ch = ch;
          issue(s, 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (pending_readings.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
    if (pending_readings.size() != 0)
      $display("%0d expected results never arrived", pending_readings.size());
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
